/* src/per_flow_packet_statistics_core_macros.svh */
// assertion macros for the per-flow packet statistics core
// expects clk and rst_n in the scope of use
`ifndef PER_FLOW_PACKET_STATISTICS_CORE_MACROS_SVH
`define PER_FLOW_PACKET_STATISTICS_CORE_MACROS_SVH

// same-cycle implication
`define PFS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfs assertion failed");

// next-cycle implication
`define PFS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfs assertion failed");

`endif

/* src/pfs_pkg.sv */
// shared types and constants of the per-flow packet statistics core
// no dependencies
package pfs_pkg;

  localparam int DEF_FLOW_SLOTS  = 4096;
  localparam int DEF_PROBE_LIMIT = 8;

  localparam logic [15:0] ETHER_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP  = 8'd6;
  localparam logic [7:0]  PROTO_UDP  = 8'd17;
  localparam logic [63:0] HASH_MUL1  = 64'h9E37_79B9_7F4A_7C15;
  localparam logic [63:0] HASH_MUL2  = 64'hBF58_476D_1CE4_E5B9;
  localparam logic [31:0] ALL_ONES32 = 32'hFFFF_FFFF;

  // result status codes
  localparam logic [1:0] ST_EXISTING = 2'd0;
  localparam logic [1:0] ST_NEW      = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  typedef struct packed {
    logic [15:0] frame_type;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port_num;
    logic [15:0] dst_port_num;
    logic [7:0]  ip_proto;
    logic [15:0] ip_total_len;
    logic [31:0] time_us;
  } pfs_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] pkt_count;
    logic [63:0] len_sum;
    logic [15:0] len_max;
    logic [15:0] len_min;
    logic [15:0] len_mean;
    logic [63:0] len_var;
    logic [31:0] ipd_last;
    logic [31:0] ipd_max;
    logic [31:0] ipd_min;
    logic [31:0] ipd_mean;
    logic [63:0] ipd_var;
  } pfs_out_t;

  // classified packet handed from front to back
  typedef struct packed {
    logic [103:0] key;
    logic [15:0]  len;
    logic [31:0]  tstamp;
  } pfs_job_t;

  // per-slot flow record
  typedef struct packed {
    logic [31:0] pkt_count;
    logic [63:0] len_sum;
    logic [63:0] len_sq;
    logic [15:0] len_max;
    logic [15:0] len_min;
    logic [31:0] last_time;
    logic [63:0] ipd_sum;
    logic [63:0] ipd_sq;
    logic [31:0] ipd_max;
    logic [31:0] ipd_min;
    logic [31:0] ipd_last;
  } pfs_flow_t;

  typedef struct packed {
    logic empty;
    logic full;
  } pfs_q_stat_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } pfs_bk_stat_t;

endpackage

/* src/pfs_div.sv */
// restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// depends on nothing
module pfs_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic [63:0] quotient
);

  logic [63:0] q_r;
  logic [31:0] rem_r;
  logic [31:0] dvs_r;
  logic [6:0]  cnt_r;
  logic        busy_r;
  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  // trial subtraction
  assign trial = {rem_r, q_r[63]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = (trial >= {1'b0, dvs_r});

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= 7'd0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= 7'd64;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      if (cnt_r == 7'd1) begin
        busy_r <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= 32'd0;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[31:0] : trial[31:0];
      q_r   <= {q_r[62:0], ge};
    end
  end

  assign busy     = busy_r;
  assign quotient = q_r;

endmodule

/* src/pfs_front.sv */
// front end: accepts headers, drops non ip tcp/udp, hashes the 5-tuple
// uses pfs_pkg
module pfs_front #(
  parameter int FLOW_SLOTS = 4096
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  pfs_pkg::pfs_in_t          in_data,
  output logic                      job_valid,
  output pfs_pkg::pfs_job_t         job,
  output logic [$clog2(FLOW_SLOTS)-1:0] job_home,
  input  logic                      q_full
);
  import pfs_pkg::*;

  localparam int SLOT_W = $clog2(FLOW_SLOTS);

  typedef enum logic [2:0] {
    F_IDLE = 3'b001,
    F_HASH = 3'b010,
    F_PUSH = 3'b100
  } f_state_t;

  f_state_t st_r, st_nxt;
  logic [2:0]  ph_r;
  logic [63:0] a_r, acc_r, acc_nxt, a_nxt, mix;
  logic [63:0] bconst, prod;
  logic [31:0] mop_a, mop_b;
  pfs_job_t    job_r;
  logic [SLOT_W-1:0] home_r;
  logic        pass;
  logic [63:0] fold;

  // classification
  assign pass = (in_data.frame_type == ETHER_IPV4) &&
                ((in_data.ip_proto == PROTO_TCP) || (in_data.ip_proto == PROTO_UDP));

  // shared 32x32 multiplier, three partial products per 64-bit product
  assign bconst = (ph_r < 3'd4) ? HASH_MUL1 : HASH_MUL2;
  always_comb begin
    mop_a = a_r[31:0];
    mop_b = bconst[31:0];
    unique case (ph_r)
      3'd1, 3'd5: mop_b = bconst[63:32];
      3'd2, 3'd6: mop_a = a_r[63:32];
      default: ;
    endcase
  end
  assign prod = {32'd0, mop_a} * {32'd0, mop_b};
  assign mix  = job_r.key[103:40] ^ acc_r;
  assign fold = acc_r ^ (acc_r >> 32);

  always_comb begin
    acc_nxt = acc_r;
    a_nxt   = a_r;
    unique case (ph_r)
      3'd0, 3'd4: acc_nxt = prod;
      3'd1, 3'd2, 3'd5, 3'd6: acc_nxt = acc_r + {prod[31:0], 32'd0};
      3'd3: begin
        a_nxt   = mix ^ (mix >> 29);
        acc_nxt = 64'd0;
      end
      default: ;
    endcase
  end

  // sequencer
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      F_IDLE: if (in_valid && pass) st_nxt = F_HASH;
      F_HASH: if (ph_r == 3'd7) st_nxt = F_PUSH;
      F_PUSH: if (!q_full) st_nxt = F_IDLE;
      default: st_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= F_IDLE;
      ph_r <= 3'd0;
    end else begin
      st_r <= st_nxt;
      if (st_r == F_HASH) begin
        ph_r <= ph_r + 3'd1;
      end else begin
        ph_r <= 3'd0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (st_r == F_IDLE && in_valid && pass) begin
      job_r.key    <= {in_data.src_addr, in_data.dst_addr, in_data.src_port_num,
                       in_data.dst_port_num, in_data.ip_proto};
      job_r.len    <= in_data.ip_total_len;
      job_r.tstamp <= in_data.time_us;
      a_r          <= {24'd0, in_data.src_port_num, in_data.dst_port_num,
                       in_data.ip_proto};
      acc_r        <= 64'd0;
    end else if (st_r == F_HASH) begin
      a_r   <= a_nxt;
      acc_r <= acc_nxt;
      if (ph_r == 3'd7) begin
        home_r <= fold[SLOT_W-1:0];
      end
    end
  end

  assign in_ready  = (st_r == F_IDLE);
  assign job_valid = (st_r == F_PUSH);
  assign job       = job_r;
  assign job_home  = home_r;

endmodule

/* src/pfs_queue.sv */
// two-entry queue between front and back
// uses pfs_pkg
module pfs_queue #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wdata,
  input  logic              pop,
  output logic [DATA_W-1:0] rdata,
  output pfs_pkg::pfs_q_stat_t stat
);
  import pfs_pkg::*;

  logic [DATA_W-1:0] ent_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wp_r] <= wdata;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      unique case ({push, pop})
        2'b10:   cnt_r <= cnt_r + 2'd1;
        2'b01:   cnt_r <= cnt_r - 2'd1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  assign rdata      = ent_r[rp_r];
  assign stat.empty = (cnt_r == 2'd0);
  assign stat.full  = (cnt_r == 2'd2);

endmodule

/* src/pfs_back.sv */
// back end: flow table probe, record update, mean and variance, result register
// uses pfs_pkg and pfs_div
module pfs_back #(
  parameter int FLOW_SLOTS  = 4096,
  parameter int PROBE_LIMIT = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  pfs_pkg::pfs_q_stat_t          q_stat,
  input  pfs_pkg::pfs_job_t             job,
  input  logic [$clog2(FLOW_SLOTS)-1:0] job_home,
  output pfs_pkg::pfs_bk_stat_t         stat,
  output logic                          out_valid,
  input  logic                          out_ready,
  output pfs_pkg::pfs_out_t             out_data
);
  import pfs_pkg::*;

  localparam int SLOT_W = $clog2(FLOW_SLOTS);
  localparam int PC_W   = $clog2(PROBE_LIMIT + 1);

  typedef enum logic [10:0] {
    B_CLEAR  = 11'b00000000001,
    B_IDLE   = 11'b00000000010,
    B_PROBE  = 11'b00000000100,
    B_CHECK  = 11'b00000001000,
    B_SREAD  = 11'b00000010000,
    B_UPDATE = 11'b00000100000,
    B_DIVIDE = 11'b00001000000,
    B_SQ_LO  = 11'b00010000000,
    B_SQ_X   = 11'b00100000000,
    B_FINISH = 11'b01000000000,
    B_EMIT   = 11'b10000000000
  } b_state_t;

  b_state_t st_r, st_nxt;

  // flow table memories
  logic [104:0] key_mem [FLOW_SLOTS];
  pfs_flow_t    stat_mem [FLOW_SLOTS];
  logic [104:0] key_q_r;
  pfs_flow_t    stat_q_r;

  pfs_job_t          job_r;
  logic [SLOT_W-1:0] slot_r, clr_r;
  logic [PC_W-1:0]   pc_r;
  logic              is_new_r, full_r, izero_r;
  pfs_flow_t         flow_r, upd;
  logic              pop;
  logic              hit, free;
  logic              out_valid_r;
  pfs_out_t          out_r, res;

  logic        key_we;
  logic [SLOT_W-1:0] key_wa;
  logic [104:0] key_wd;

  logic [31:0] dly;
  logic [31:0] len_sq;
  logic [63:0] dly_sq;
  logic [31:0] ipd_n;

  logic        div_busy [4];
  logic [63:0] quo [4];
  logic        div_go;

  logic [63:0] sql_r, sqi_r;
  logic [31:0] xl_r, xi_r;
  logic [63:0] lvar_r, ivar_r;
  logic [63:0] q_lsum, q_lsq, q_isum, q_isq;

  assign free = !key_q_r[104];
  assign hit  = key_q_r[104] && (key_q_r[103:0] == job_r.key);
  assign pop  = (st_r == B_IDLE) && !q_stat.empty;

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      B_CLEAR:  if (clr_r == SLOT_W'(FLOW_SLOTS - 1)) st_nxt = B_IDLE;
      B_IDLE:   if (!q_stat.empty) st_nxt = B_PROBE;
      B_PROBE:  st_nxt = B_CHECK;
      B_CHECK: begin
        priority if (free)                          st_nxt = B_UPDATE;
        else if (hit)                               st_nxt = B_SREAD;
        else if (pc_r == PC_W'(PROBE_LIMIT - 1))    st_nxt = B_EMIT;
        else                                        st_nxt = B_PROBE;
      end
      B_SREAD:  st_nxt = B_UPDATE;
      B_UPDATE: st_nxt = B_DIVIDE;
      B_DIVIDE: if (!div_busy[0]) st_nxt = B_SQ_LO;
      B_SQ_LO:  st_nxt = B_SQ_X;
      B_SQ_X:   st_nxt = B_FINISH;
      B_FINISH: st_nxt = B_EMIT;
      B_EMIT:   if (!out_valid_r || out_ready) st_nxt = B_IDLE;
      default:  st_nxt = B_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= B_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (st_r == B_CLEAR) begin
        clr_r <= clr_r + SLOT_W'(1);
      end
      if (st_r == B_EMIT && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // probe bookkeeping
  always_ff @(posedge clk) begin
    if (pop) begin
      job_r    <= job;
      slot_r   <= job_home;
      pc_r     <= '0;
      full_r   <= 1'b0;
      is_new_r <= 1'b0;
    end else if (st_r == B_CHECK) begin
      if (free) begin
        is_new_r <= 1'b1;
      end else if (!hit) begin
        if (pc_r == PC_W'(PROBE_LIMIT - 1)) begin
          full_r <= 1'b1;
        end else begin
          pc_r   <= pc_r + PC_W'(1);
          slot_r <= slot_r + SLOT_W'(1);
        end
      end
    end
  end

  // key memory write port: clearing pass or insertion
  always_comb begin
    key_we = 1'b0;
    key_wa = slot_r;
    key_wd = {1'b1, job_r.key};
    if (st_r == B_CLEAR) begin
      key_we = 1'b1;
      key_wa = clr_r;
      key_wd = '0;
    end else if (st_r == B_UPDATE && is_new_r) begin
      key_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_wa] <= key_wd;
    end
    if (st_r == B_PROBE) begin
      key_q_r <= key_mem[slot_r];
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == B_UPDATE) begin
      stat_mem[slot_r] <= upd;
    end
    if (st_r == B_SREAD) begin
      stat_q_r <= stat_mem[slot_r];
    end
  end

  // record update
  assign dly    = job_r.tstamp - stat_q_r.last_time;
  assign len_sq = {16'd0, job_r.len} * {16'd0, job_r.len};
  assign dly_sq = {32'd0, dly} * {32'd0, dly};

  always_comb begin
    if (is_new_r) begin
      upd.pkt_count = 32'd1;
      upd.len_sum   = {48'd0, job_r.len};
      upd.len_sq    = {32'd0, len_sq};
      upd.len_max   = job_r.len;
      upd.len_min   = job_r.len;
      upd.last_time = job_r.tstamp;
      upd.ipd_sum   = 64'd0;
      upd.ipd_sq    = 64'd0;
      upd.ipd_max   = 32'd0;
      upd.ipd_min   = ALL_ONES32;
      upd.ipd_last  = 32'd0;
    end else begin
      upd.pkt_count = (stat_q_r.pkt_count == ALL_ONES32) ? ALL_ONES32
                                                         : stat_q_r.pkt_count + 32'd1;
      upd.len_sum   = stat_q_r.len_sum + {48'd0, job_r.len};
      upd.len_sq    = stat_q_r.len_sq + {32'd0, len_sq};
      upd.len_max   = (job_r.len > stat_q_r.len_max) ? job_r.len : stat_q_r.len_max;
      upd.len_min   = (job_r.len < stat_q_r.len_min) ? job_r.len : stat_q_r.len_min;
      upd.last_time = job_r.tstamp;
      upd.ipd_sum   = stat_q_r.ipd_sum + {32'd0, dly};
      upd.ipd_sq    = stat_q_r.ipd_sq + dly_sq;
      upd.ipd_max   = (dly > stat_q_r.ipd_max) ? dly : stat_q_r.ipd_max;
      upd.ipd_min   = (dly < stat_q_r.ipd_min) ? dly : stat_q_r.ipd_min;
      upd.ipd_last  = dly;
    end
  end

  assign ipd_n  = upd.pkt_count - 32'd1;
  assign div_go = (st_r == B_UPDATE);

  always_ff @(posedge clk) begin
    if (st_r == B_UPDATE) begin
      flow_r  <= upd;
      izero_r <= (ipd_n == 32'd0);
    end
  end

  // four dividers run side by side
  pfs_div u_div_lsum (.clk, .rst_n, .start(div_go), .dividend(upd.len_sum),
                      .divisor(upd.pkt_count), .busy(div_busy[0]), .quotient(quo[0]));
  pfs_div u_div_lsq  (.clk, .rst_n, .start(div_go), .dividend(upd.len_sq),
                      .divisor(upd.pkt_count), .busy(div_busy[1]), .quotient(quo[1]));
  pfs_div u_div_isum (.clk, .rst_n, .start(div_go), .dividend(upd.ipd_sum),
                      .divisor(ipd_n), .busy(div_busy[2]), .quotient(quo[2]));
  pfs_div u_div_isq  (.clk, .rst_n, .start(div_go), .dividend(upd.ipd_sq),
                      .divisor(ipd_n), .busy(div_busy[3]), .quotient(quo[3]));

  assign q_lsum = quo[0];
  assign q_lsq  = quo[1];
  assign q_isum = quo[2];
  assign q_isq  = quo[3];

  // mean squared modulo 2^64 from 32x32 partial products
  always_ff @(posedge clk) begin
    if (st_r == B_SQ_LO) begin
      sql_r <= {32'd0, q_lsum[31:0]} * {32'd0, q_lsum[31:0]};
      sqi_r <= {32'd0, q_isum[31:0]} * {32'd0, q_isum[31:0]};
    end
    if (st_r == B_SQ_X) begin
      xl_r <= q_lsum[31:0] * q_lsum[63:32];
      xi_r <= q_isum[31:0] * q_isum[63:32];
    end
    if (st_r == B_FINISH) begin
      lvar_r <= q_lsq - (sql_r + {xl_r[30:0], 1'b0, 32'd0});
      ivar_r <= q_isq - (sqi_r + {xi_r[30:0], 1'b0, 32'd0});
    end
  end

  // result assembly
  always_comb begin
    res = '0;
    if (full_r) begin
      res.status = ST_FULL;
    end else begin
      res.status    = is_new_r ? ST_NEW : ST_EXISTING;
      res.pkt_count = flow_r.pkt_count;
      res.len_sum   = flow_r.len_sum;
      res.len_max   = flow_r.len_max;
      res.len_min   = flow_r.len_min;
      res.len_mean  = q_lsum[15:0];
      res.len_var   = lvar_r;
      res.ipd_last  = flow_r.ipd_last;
      res.ipd_max   = flow_r.ipd_max;
      res.ipd_min   = flow_r.ipd_min;
      res.ipd_mean  = izero_r ? 32'd0 : q_isum[31:0];
      res.ipd_var   = izero_r ? 64'd0 : ivar_r;
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == B_EMIT && (!out_valid_r || out_ready)) begin
      out_r <= res;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.clearing = (st_r == B_CLEAR);
  assign stat.pop      = pop;

endmodule

/* src/per_flow_packet_statistics_core.sv */
// per-flow packet statistics core, top level
// uses pfs_pkg, pfs_front, pfs_queue, pfs_back and the assertion macro header
//
// in_*: one parsed header per transaction (valid/ready). Headers that are not
// IPv4 carrying TCP or UDP are taken and dropped without a result.
// out_*: one statistics record per kept header, in arrival order.
// The front takes a header, hashes the 5-tuple in F_HASH and hands the job to
// a two-entry queue from F_PUSH, where a full queue holds it; it takes no new
// header until the job is pushed. The back probes the flow table (B_PROBE,
// B_CHECK per slot visited, up to PROBE_LIMIT slots), reads and writes the
// flow record (B_SREAD for a known flow, B_UPDATE), runs four bit-serial
// dividers side by side (B_DIVIDE) and squares the means in B_SQ_LO, B_SQ_X
// and B_FINISH. A full probe window gives a table_full result after the
// probes alone.
// After reset the back clears the valid bits of the flow table, one slot a
// cycle, before it takes a header from the queue.
// A stalled receiver holds the result register; the back then waits in its
// last step while the front keeps filling the queue.
`include "per_flow_packet_statistics_core_macros.svh"

module per_flow_packet_statistics_core #(
  parameter int FLOW_SLOTS  = pfs_pkg::DEF_FLOW_SLOTS,
  parameter int PROBE_LIMIT = pfs_pkg::DEF_PROBE_LIMIT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pfs_pkg::pfs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pfs_pkg::pfs_out_t out_data
);
  import pfs_pkg::*;

  localparam int SLOT_W = $clog2(FLOW_SLOTS);
  localparam int JOB_W  = $bits(pfs_job_t) + SLOT_W;

  logic              push;
  pfs_job_t          f_job, b_job;
  logic [SLOT_W-1:0] f_home, b_home;
  logic [JOB_W-1:0]  q_rdata;
  pfs_q_stat_t       q_stat;
  pfs_bk_stat_t      bk_stat;
  logic              job_valid;

  // classify and hash
  pfs_front #(.FLOW_SLOTS(FLOW_SLOTS)) u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_data,
    .job_valid, .job(f_job), .job_home(f_home), .q_full(q_stat.full)
  );

  assign push = job_valid && !q_stat.full;

  pfs_queue #(.DATA_W(JOB_W)) u_queue (
    .clk, .rst_n, .push, .wdata({f_home, f_job}), .pop(bk_stat.pop),
    .rdata(q_rdata), .stat(q_stat)
  );

  assign b_job  = q_rdata[$bits(pfs_job_t)-1:0];
  assign b_home = q_rdata[JOB_W-1:$bits(pfs_job_t)];

  // table and statistics
  pfs_back #(.FLOW_SLOTS(FLOW_SLOTS), .PROBE_LIMIT(PROBE_LIMIT)) u_back (
    .clk, .rst_n, .q_stat, .job(b_job), .job_home(b_home), .stat(bk_stat),
    .out_valid, .out_ready, .out_data
  );

  // checks
  `PFS_ASSERT_IMP(a_no_push_full, push, !q_stat.full)
  `PFS_ASSERT_IMP(a_no_pop_clear, bk_stat.clearing, !bk_stat.pop)
  `PFS_ASSERT_NEXT(a_push_fills, push, !q_stat.empty)
  `PFS_ASSERT_IMP(a_full_zero, out_valid && (out_data.status == ST_FULL), out_data.pkt_count == 32'd0)

endmodule
